@@ rtl/heps_pkg.sv @@
// shared types, constants and saturation helpers for the heston euler path step
// no dependencies
package heps_pkg;

    localparam int FRAC_BITS = 24;
    localparam int NORM_FRAC = 12;
    localparam int MAX_SEGMENTS = 1024;
    localparam int SQ_WIDTH = 56;
    localparam int SQ_STEPS = SQ_WIDTH / 2;
    localparam int DIV_WIDTH = 57;
    localparam int ITER_WIDTH = 6;

    localparam logic [2:0] REG_DRIFT_MU_H   = 3'd0;
    localparam logic [2:0] REG_KAPPA        = 3'd1;
    localparam logic [2:0] REG_THETA        = 3'd2;
    localparam logic [2:0] REG_SIGMA        = 3'd3;
    localparam logic [2:0] REG_RHO          = 3'd4;
    localparam logic [2:0] REG_STEP_DT      = 3'd5;
    localparam logic [2:0] REG_SQRT_STEP_DT = 3'd6;
    localparam logic [2:0] REG_SEGMENTS     = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RHO_SQ,
        ST_RC_SQRT,
        ST_V_LOAD,
        ST_V_SQRT,
        ST_M_SD,
        ST_M_E1,
        ST_M_E2,
        ST_M_DK,
        ST_M_DRIFT,
        ST_M_SE,
        ST_SUM,
        ST_DIV,
        ST_M_IV,
        ST_ACC,
        ST_FIN
    } state_t;

    // y terms share the last multiplier slots, tracked by a phase bit
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) r = 32'sh7FFFFFFF;
        else if (x < -66'sd2147483648) r = 32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [65:0] x);
        return (x > 66'sd2147483647) || (x < -66'sd2147483648);
    endfunction

endpackage

@@ rtl/heston_euler_path_step.sv @@
// heston euler path step: one sub-step per item, interval return on the last sub-step
// depends on heps_pkg (state type, constants, saturation helpers)
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    normal_a, normal_b, new_path, start_variance
// out       output     out_valid / out_ready  path_return, end_variance, overflow
// cfg       input      apb psel/penable       8 registers at 4*i
//
// an item is taken in idle and the root is loaded, then come the bit-per-cycle variance
// root, one per product on the single shared multiplier and the sum and accumulate steps,
// plus the correlation root on a new path, the shock back-solve divider when the variance
// truncates and sigma is nonzero, and the return products on the last sub-step
// reset is asynchronous, active low; no clearing pass is needed
// a finished result waits in the output register; the sequencer stalls only if a
// second result is ready while the first is still untaken
module heston_euler_path_step
    import heps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  normal_a,
    input  logic signed [15:0]  normal_b,
    input  logic                new_path,
    input  logic [30:0]         start_variance,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  path_return,
    output logic [30:0]         end_variance,
    output logic                overflow,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // configuration
    logic signed [31:0] drift_reg;
    logic [30:0]        kappa_reg;
    logic [30:0]        theta_reg;
    logic [30:0]        sigma_reg;
    logic signed [25:0] rho_reg;
    logic [24:0]        dt_reg;
    logic [24:0]        sdt_reg;
    logic [10:0]        seg_reg;

    state_t state_reg, state_next;

    logic signed [15:0] na_reg, na_next, nb_reg, nb_next;
    logic signed [31:0] var_reg, var_next, svs_reg, svs_next, srs_reg, srs_next;
    logic signed [31:0] siv_reg, siv_next, rc_reg, rc_next;
    logic [9:0]         cnt_reg, cnt_next;
    logic               sat_reg, sat_next;
    logic signed [31:0] sd_reg, sd_next, e1_reg, e1_next, e2_reg, e2_next;
    logic signed [31:0] dk_reg, dk_next, drift_t_reg, drift_t_next;
    logic signed [31:0] term_reg, term_next, vn_reg, vn_next, ivt_reg, ivt_next;
    logic               yph_reg, yph_next;
    logic [SQ_WIDTH-1:0]  sqx_reg, sqx_next, sqr_reg, sqr_next, sqb_reg, sqb_next;
    logic [ITER_WIDTH-1:0] iter_reg, iter_next;
    logic [DIV_WIDTH-1:0] dq_reg, dq_next;
    logic [31:0]          rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [31:0]   out_ret_reg, out_ret_next;
    logic [30:0]          out_var_reg, out_var_next;
    logic                 out_ovf_reg, out_ovf_next;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p, mul_s;
    logic [1:0]         mul_sh;
    logic signed [31:0] mul_q;
    logic               mul_o;

    // sqrt step
    logic [SQ_WIDTH-1:0] sq_t, sq_r_step;
    logic                sq_ge;

    // divider step
    logic [31:0]          dv_r2;
    logic                 dv_ge;
    logic [DIV_WIDTH-1:0] dq_step;

    logic signed [65:0] rho_d;
    logic signed [33:0] vsum, bs_t;
    logic [33:0]        bs_mag;
    logic signed [65:0] div_val, diff_w, y_w;
    logic signed [31:0] diff, vn_sat;
    logic [10:0]        seg_eff, cnt_inc;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_DRIFT_MU_H:   prdata = drift_reg;
            REG_KAPPA:        prdata = {1'b0, kappa_reg};
            REG_THETA:        prdata = {1'b0, theta_reg};
            REG_SIGMA:        prdata = {1'b0, sigma_reg};
            REG_RHO:          prdata = 32'(rho_reg);
            REG_STEP_DT:      prdata = {7'b0, dt_reg};
            REG_SQRT_STEP_DT: prdata = {7'b0, sdt_reg};
            REG_SEGMENTS:     prdata = {21'b0, seg_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg <= '0;
            kappa_reg <= '0;
            theta_reg <= '0;
            sigma_reg <= '0;
            rho_reg   <= '0;
            dt_reg    <= 25'd1677722;
            sdt_reg   <= 25'd5305422;
            seg_reg   <= 11'd10;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_DRIFT_MU_H:   drift_reg <= pwdata;
                REG_KAPPA:        kappa_reg <= pwdata[30:0];
                REG_THETA:        theta_reg <= pwdata[30:0];
                REG_SIGMA:        sigma_reg <= pwdata[30:0];
                REG_RHO:          rho_reg   <= pwdata[25:0];
                REG_STEP_DT:      dt_reg    <= pwdata[24:0];
                REG_SQRT_STEP_DT: sdt_reg   <= pwdata[24:0];
                REG_SEGMENTS:     seg_reg   <= pwdata[10:0];
                default:          ;
            endcase
        end
    end

    // operand select
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = 2'd2;
        case (state_reg)
            ST_RHO_SQ:
            begin
                mul_a  = 33'(rho_reg);
                mul_b  = 33'(rho_reg);
                mul_sh = 2'd0;
            end
            ST_M_SD:
            begin
                mul_a = 33'(sd_reg);
                mul_b = $signed({8'b0, sdt_reg});
            end
            ST_M_E1:
            begin
                mul_a  = 33'(sd_reg);
                mul_b  = 33'(na_reg);
                mul_sh = 2'd1;
            end
            ST_M_E2:
            begin
                mul_a  = 33'(sd_reg);
                mul_b  = 33'(nb_reg);
                mul_sh = 2'd1;
            end
            ST_M_DK:
            begin
                mul_a = $signed({8'b0, dt_reg});
                mul_b = $signed({2'b0, kappa_reg});
            end
            ST_M_DRIFT:
            begin
                mul_a = 33'(dk_reg);
                mul_b = 33'(diff);
            end
            ST_M_SE:
            begin
                mul_a = $signed({2'b0, sigma_reg});
                mul_b = 33'(e1_reg);
            end
            ST_M_IV:
            begin
                mul_a = 33'(var_reg);
                mul_b = $signed({8'b0, dt_reg});
            end
            ST_ACC:
            begin
                mul_a = yph_reg ? 33'(rc_reg) : 33'(rho_reg);
                mul_b = yph_reg ? 33'(srs_reg) : 33'(svs_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (mul_sh)
            2'd0:    mul_s = mul_p;
            2'd1:    mul_s = mul_p >>> NORM_FRAC;
            default: mul_s = mul_p >>> FRAC_BITS;
        endcase
    end

    assign mul_q = sat32(mul_s);
    assign mul_o = ovf32(mul_s);

    assign sq_t      = sqr_reg + sqb_reg;
    assign sq_ge     = sqx_reg >= sq_t;
    assign sq_r_step = sq_ge ? (sqr_reg >> 1) + sqb_reg : sqr_reg >> 1;

    assign dv_r2   = {rem_reg[30:0], dq_reg[DIV_WIDTH-1]};
    assign dv_ge   = dv_r2 >= {1'b0, sigma_reg};
    assign dq_step = {dq_reg[DIV_WIDTH-2:0], dv_ge};

    assign rho_d  = (66'sd1 <<< (2 * FRAC_BITS)) - mul_p;
    assign diff_w = 66'($signed({1'b0, theta_reg})) - 66'(var_reg);
    assign diff   = sat32(diff_w);
    assign vsum   = 34'(var_reg) + 34'(drift_t_reg) + 34'(term_reg);
    assign vn_sat = sat32(66'(vsum));
    assign bs_t   = -34'(var_reg) - 34'(drift_t_reg);
    assign bs_mag = bs_t[33] ? 34'(-bs_t) : 34'(bs_t);
    assign div_val = neg_reg ? -66'({1'b0, dq_step}) : 66'({1'b0, dq_step});
    assign y_w    = 66'(drift_reg) - 66'(siv_reg >>> 1) + 66'(dk_reg) + 66'(mul_q);

    assign seg_eff = (seg_reg == 11'd0) ? 11'd1 :
                     (seg_reg > 11'(MAX_SEGMENTS)) ? 11'(MAX_SEGMENTS) : seg_reg;
    assign cnt_inc = {1'b0, cnt_reg} + 11'd1;

    always_comb
    begin
        state_next     = state_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        var_next       = var_reg;
        svs_next       = svs_reg;
        srs_next       = srs_reg;
        siv_next       = siv_reg;
        rc_next        = rc_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        sd_next        = sd_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        dk_next        = dk_reg;
        drift_t_next   = drift_t_reg;
        term_next      = term_reg;
        vn_next        = vn_reg;
        ivt_next       = ivt_reg;
        yph_next       = yph_reg;
        sqx_next       = sqx_reg;
        sqr_next       = sqr_reg;
        sqb_next       = sqb_reg;
        iter_next      = iter_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_ret_next   = out_ret_reg;
        out_var_next   = out_var_reg;
        out_ovf_next   = out_ovf_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    na_next = normal_a;
                    nb_next = normal_b;
                    if (new_path)
                    begin
                        var_next   = {1'b0, start_variance};
                        svs_next   = '0;
                        srs_next   = '0;
                        siv_next   = '0;
                        cnt_next   = '0;
                        sat_next   = 1'b0;
                        state_next = ST_RHO_SQ;
                    end
                    else
                        state_next = ST_V_LOAD;
                end
            end
            ST_RHO_SQ:
            begin
                sqx_next   = rho_d[65] ? '0 : rho_d[SQ_WIDTH-1:0];
                sqr_next   = '0;
                sqb_next   = SQ_WIDTH'(1) << (SQ_WIDTH - 2);
                iter_next  = '0;
                state_next = ST_RC_SQRT;
            end
            ST_RC_SQRT, ST_V_SQRT:
            begin
                if (sq_ge)
                    sqx_next = sqx_reg - sq_t;
                sqr_next  = sq_r_step;
                sqb_next  = sqb_reg >> 2;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_WIDTH'(SQ_STEPS - 1))
                begin
                    if (state_reg == ST_RC_SQRT)
                    begin
                        rc_next    = sq_r_step[31:0];
                        state_next = ST_V_LOAD;
                    end
                    else
                    begin
                        sd_next    = sq_r_step[31:0];
                        state_next = ST_M_SD;
                    end
                end
            end
            ST_V_LOAD:
            begin
                sqx_next   = SQ_WIDTH'(var_reg[30:0]) << FRAC_BITS;
                sqr_next   = '0;
                sqb_next   = SQ_WIDTH'(1) << (SQ_WIDTH - 2);
                iter_next  = '0;
                state_next = ST_V_SQRT;
            end
            ST_M_SD:
            begin
                sd_next    = mul_q;
                sat_next   = sat_reg | mul_o;
                state_next = ST_M_E1;
            end
            ST_M_E1:
            begin
                e1_next    = mul_q;
                sat_next   = sat_reg | mul_o;
                state_next = ST_M_E2;
            end
            ST_M_E2:
            begin
                e2_next    = mul_q;
                sat_next   = sat_reg | mul_o;
                state_next = ST_M_DK;
            end
            ST_M_DK:
            begin
                dk_next    = mul_q;
                sat_next   = sat_reg | mul_o;
                state_next = ST_M_DRIFT;
            end
            ST_M_DRIFT:
            begin
                drift_t_next = mul_q;
                sat_next     = sat_reg | mul_o | ovf32(diff_w);
                state_next   = ST_M_SE;
            end
            ST_M_SE:
            begin
                term_next  = mul_q;
                sat_next   = sat_reg | mul_o;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sat_next   = sat_reg | ovf32(66'(vsum));
                vn_next    = vn_sat;
                state_next = ST_M_IV;
                if (vn_sat[31])
                begin
                    vn_next = '0;
                    if (sigma_reg != '0)
                    begin
                        neg_next   = bs_t[33];
                        dq_next    = DIV_WIDTH'(bs_mag) << FRAC_BITS;
                        rem_next   = '0;
                        iter_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = dv_ge ? dv_r2 - {1'b0, sigma_reg} : dv_r2;
                dq_next   = dq_step;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_WIDTH'(DIV_WIDTH - 1))
                begin
                    e1_next    = sat32(div_val);
                    sat_next   = sat_reg | ovf32(div_val);
                    state_next = ST_M_IV;
                end
            end
            ST_M_IV:
            begin
                ivt_next   = mul_q;
                sat_next   = sat_reg | mul_o;
                yph_next   = 1'b0;
                state_next = ST_ACC;
                // accumulate here, then reuse ST_ACC for the two y products
                svs_next = sat32(66'(svs_reg) + 66'(e1_reg));
                srs_next = sat32(66'(srs_reg) + 66'(e2_reg));
                sat_next = sat_reg | mul_o | ovf32(66'(svs_reg) + 66'(e1_reg))
                         | ovf32(66'(srs_reg) + 66'(e2_reg));
            end
            ST_ACC:
            begin
                if (!yph_reg && iter_reg != '1)
                begin
                    // first pass: integrated variance and count
                    siv_next  = sat32(66'(siv_reg) + 66'(ivt_reg));
                    sat_next  = sat_reg | ovf32(66'(siv_reg) + 66'(ivt_reg));
                    var_next  = vn_reg;
                    iter_next = '1;
                    if (cnt_inc < seg_eff)
                    begin
                        cnt_next   = cnt_inc[9:0];
                        state_next = ST_IDLE;
                    end
                end
                else if (!yph_reg)
                begin
                    dk_next  = mul_q;
                    sat_next = sat_reg | mul_o;
                    yph_next = 1'b1;
                end
                else
                begin
                    ivt_next   = mul_q;
                    sat_next   = sat_reg | mul_o;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_ret_next   = sat32(y_w - 66'(mul_q) + 66'(ivt_reg));
                    out_var_next   = var_reg[30:0];
                    out_ovf_next   = sat_reg | ovf32(y_w - 66'(mul_q) + 66'(ivt_reg));
                    out_valid_next = 1'b1;
                    svs_next       = '0;
                    srs_next       = '0;
                    siv_next       = '0;
                    cnt_next       = '0;
                    sat_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            var_reg       <= '0;
            svs_reg       <= '0;
            srs_reg       <= '0;
            siv_reg       <= '0;
            rc_reg        <= 32'sd1 <<< FRAC_BITS;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            yph_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            var_reg       <= var_next;
            svs_reg       <= svs_next;
            srs_reg       <= srs_next;
            siv_reg       <= siv_next;
            rc_reg        <= rc_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            yph_reg       <= yph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg      <= na_next;
        nb_reg      <= nb_next;
        sd_reg      <= sd_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        dk_reg      <= dk_next;
        drift_t_reg <= drift_t_next;
        term_reg    <= term_next;
        vn_reg      <= vn_next;
        ivt_reg     <= ivt_next;
        sqx_reg     <= sqx_next;
        sqr_reg     <= sqr_next;
        sqb_reg     <= sqb_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        out_ret_reg <= out_ret_next;
        out_var_reg <= out_var_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign path_return  = out_ret_reg;
    assign end_variance = out_var_reg;
    assign overflow     = out_ovf_reg;

endmodule

@@ sim/heps_checker.sv @@
// item predictor and result checker for heston_euler_path_step
// watches the input, output and apb channels; depends on heps_pkg register indexes
module heps_checker
    import heps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic signed [15:0]  normal_a,
    input  logic signed [15:0]  normal_b,
    input  logic                new_path,
    input  logic [30:0]         start_variance,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [31:0]  path_return,
    input  logic [30:0]         end_variance,
    input  logic                overflow,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] ret;
        logic [30:0]        var_end;
        logic               ovf;
    } interval_t;

    interval_t returns_due[$];

    longint mu_h, rho_q, kappa_q, theta_q, sigma_q, dt_q, sqdt_q, seg_q;
    longint var_q, acc_e1, acc_e2, acc_iv, rc_q;
    int unsigned count_q;
    bit sat_q;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647)
        begin
            sat_q = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            sat_q = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint mulq(longint a, longint b, int s);
        return clip32((a * b) >>> s);
    endfunction

    function automatic longint rho_comp();
        longint d;
        d = (64'sd1 << (2 * FRAC_BITS)) - rho_q * rho_q;
        if (d < 0)
            d = 0;
        return root(d);
    endfunction

    task automatic clear_interval();
        acc_e1 = 0;
        acc_e2 = 0;
        acc_iv = 0;
        count_q = 0;
        sat_q = 0;
    endtask

    task automatic predict_substep();
        longint seg, v0, sd, e1, e2, dk, diff, drift, vn, y;
        interval_t r;
        seg = seg_q;
        if (new_path)
        begin
            clear_interval();
            var_q = clip32(longint'(start_variance));
            rc_q = clip32(rho_comp());
        end
        if (seg == 0)
            seg = 1;
        if (seg > MAX_SEGMENTS)
            seg = MAX_SEGMENTS;
        v0 = var_q;
        sd = clip32(root(longint'(v0) << FRAC_BITS));
        sd = mulq(sd, sqdt_q, FRAC_BITS);
        e1 = mulq(sd, longint'(normal_a), NORM_FRAC);
        e2 = mulq(sd, longint'(normal_b), NORM_FRAC);
        dk = mulq(dt_q, kappa_q, FRAC_BITS);
        diff = clip32(theta_q - v0);
        drift = mulq(dk, diff, FRAC_BITS);
        vn = clip32(v0 + drift + mulq(sigma_q, e1, FRAC_BITS));
        if (vn < 0)
        begin
            vn = 0;
            if (sigma_q != 0)
                e1 = clip32(((-v0 - drift) * (64'sd1 << FRAC_BITS)) / sigma_q);
        end
        acc_e1 = clip32(acc_e1 + e1);
        acc_e2 = clip32(acc_e2 + e2);
        acc_iv = clip32(acc_iv + mulq(v0, dt_q, FRAC_BITS));
        var_q = vn;
        if (longint'(count_q) + 1 < seg)
        begin
            count_q = (count_q + 1) & 10'h3FF;
            return;
        end
        y = mu_h - (acc_iv >>> 1) + mulq(rho_q, acc_e1, FRAC_BITS)
            + mulq(rc_q, acc_e2, FRAC_BITS);
        y = clip32(y);
        r.ret = y[31:0];
        r.var_end = vn[30:0];
        r.ovf = sat_q;
        returns_due.push_back(r);
        clear_interval();
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        interval_t e;
        if (!rst_n)
        begin
            errors = 0;
            returns_due.delete();
            pending = 0;
            mu_h = 0; kappa_q = 0; theta_q = 0; sigma_q = 0; rho_q = 0;
            dt_q = 1677722; sqdt_q = 5305422; seg_q = 10;
            var_q = 0;
            clear_interval();
            rc_q = clip32(rho_comp());
            sat_q = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_DRIFT_MU_H:   mu_h = longint'(signed'(pwdata));
                    REG_KAPPA:        kappa_q = pwdata[30:0];
                    REG_THETA:        theta_q = pwdata[30:0];
                    REG_SIGMA:        sigma_q = pwdata[30:0];
                    REG_RHO:          rho_q = longint'(signed'(pwdata[25:0]));
                    REG_STEP_DT:      dt_q = pwdata[24:0];
                    REG_SQRT_STEP_DT: sqdt_q = pwdata[24:0];
                    REG_SEGMENTS:     seg_q = pwdata[10:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (returns_due.size() == 0)
                    report("unexpected output item", 1, 0);
                else
                begin
                    e = returns_due.pop_front();
                    if (path_return !== e.ret)
                        report("path_return", path_return, e.ret);
                    if (end_variance !== e.var_end)
                        report("end_variance", end_variance, e.var_end);
                    if (overflow !== e.ovf)
                        report("overflow", overflow, e.ovf);
                end
            end
            if (in_valid && in_ready)
                predict_substep();
            pending = returns_due.size();
        end
    end
endmodule

@@ sim/testbench.sv @@
// top of the heston_euler_path_step bench: clock, reset, apb writes, item stimulus
// depends on heps_pkg, the block and heps_checker
module testbench
    import heps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LIMIT = 4000000;
    localparam int SETTLE = 200;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] normal_a, normal_b;
    logic new_path;
    logic [30:0] start_variance;
    logic signed [31:0] path_return;
    logic [30:0] end_variance;
    logic overflow;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    int errors, pending;
    int send_idle, recv_stall;
    bit hold_off;
    longint cycles;

    heston_euler_path_step DUT (.*);
    heps_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        int n;
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 0;
                for (n = 0; n < 2000; n++)
                    @(negedge clk);
                hold_off = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic send(logic signed [15:0] a, logic signed [15:0] b, logic np,
                        logic [30:0] sv);
        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            in_valid <= 0;
        end
        @(negedge clk);
        in_valid <= 1;
        normal_a <= a; normal_b <= b; new_path <= np; start_variance <= sv;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic configure(logic [31:0] mu, logic [31:0] k, logic [31:0] th,
                             logic [31:0] sg, logic [31:0] r, logic [31:0] dt,
                             logic [31:0] sq, logic [31:0] seg);
        reg_write(REG_DRIFT_MU_H, mu);
        reg_write(REG_KAPPA, k);
        reg_write(REG_THETA, th);
        reg_write(REG_SIGMA, sg);
        reg_write(REG_RHO, r);
        reg_write(REG_STEP_DT, dt);
        reg_write(REG_SQRT_STEP_DT, sq);
        reg_write(REG_SEGMENTS, seg);
    endtask

    task automatic random_config(int max_seg);
        configure($urandom_range(2000000) - 1000000, $urandom_range(67108864),
                  $urandom_range(3000000), $urandom_range(33554432),
                  $urandom_range(33554432) - 16777216, $urandom_range(3355443),
                  $urandom_range(7500000), $urandom_range(max_seg));
    endtask

    task automatic random_items(int count, bit restarts);
        int i;
        logic signed [15:0] a, b;
        logic [30:0] sv;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                a = 16'($urandom);
                b = 16'($urandom);
            end
            else
            begin
                a = 16'($urandom_range(16383) - 8192);
                b = 16'($urandom_range(16383) - 8192);
            end
            sv = ($urandom_range(15) == 0) ? 31'($urandom) : 31'($urandom_range(8000000));
            send(a, b, (i == 0) || (restarts && ($urandom_range(11) == 0)), sv);
        end
    endtask

    initial
    begin
        int p;
        rst_n = 0;
        in_valid = 0; normal_a = 0; normal_b = 0; new_path = 0; start_variance = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        send_idle = 0; recv_stall = 0; hold_off = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // defaults after reset, then extremes of the item fields
        send(16'sh7FFF, 16'sh8000, 1'b1, 31'h7FFFFFFF);
        send(16'sh8000, 16'sh7FFF, 1'b0, 31'd0);
        send(16'sh0, 16'sh0, 1'b1, 31'd0);
        send(16'sh1000, -16'sh1000, 1'b0, 31'd0);
        send(16'sh7FFF, 16'sh7FFF, 1'b1, 31'd1000000);
        repeat (5) send(-16'sh2000, 16'sh2000, 1'b0, 31'd0);
        wait_quiet();
        // large sigma with negative normals forces truncation and back-solve
        configure(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'd16777216, 32'd16777216, 32'd16777216, 32'd0);
        send(16'sh8000, 16'sh7FFF, 1'b1, 31'd4000000);
        send(16'sh8000, 16'sh8000, 1'b0, 31'd0);
        send(16'sh7FFF, 16'sh7FFF, 1'b1, 31'h7FFFFFFF);
        wait_quiet();
        // zero sigma, truncation clamps only; rho at minus one
        configure(32'h80000000, 32'd50000000, 32'd0, 32'd0, -32'sd16777216, 32'd1677722,
                  32'd5305422, 32'd1);
        send(16'sh8000, 16'sh1000, 1'b1, 31'd2000000);
        send(16'sh7FFF, 16'sh8000, 1'b0, 31'd0);
        wait_quiet();
        // correlation beyond one and a mid sigma truncation
        configure(32'd0, 32'd16777216, 32'd600000, 32'd50000000, 32'h01FFFFFF, 32'd167772,
                  32'd1677722, 32'd2);
        send(16'sh8000, 16'sh7FFF, 1'b1, 31'd300000);
        send(16'sh8000, 16'sh8000, 1'b0, 31'd0);
        send(16'sh4000, 16'sh4000, 1'b1, 31'd100);
        send(16'sh0, 16'sh7FFF, 1'b0, 31'd0);
        wait_quiet();

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 67; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 67; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            random_config(p == 0 ? 0 : 8);
            if (p == 2)
                hold_off = 1;
            random_items(50, 1'b1);
            wait_quiet();
        end

        // segments beyond the maximum act as the maximum, one interval
        send_idle = 0; recv_stall = 0;
        random_config(1);
        reg_write(REG_SEGMENTS, 32'd2047);
        random_items(1024, 1'b0);
        wait_quiet();

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
